// File: rtl/phsm_pkg.sv
package phsm_pkg;

   localparam int HASH_W = 32;
   localparam int BYTE_W = 8;
   localparam int LENGTH_W = 7;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [HASH_W-1:0] HASH_BASE = 32'd31;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_HASH = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH = 1'd1;

   typedef struct packed {
      logic [HASH_W-1:0] hash_now;
      logic [HASH_W-1:0] hash_prev;
      logic [HASH_W-1:0] power_start;
      logic              window_ready;
      logic              window_first;
      logic              length_one;
      logic              last;
   } phsm_stage_type;

   function automatic logic [HASH_W-1:0] times_base(input logic [HASH_W-1:0] value);
      return (value << 5) - value;
   endfunction

endpackage

// File: rtl/phsm_if.sv
interface phsm_req_if;
   logic                          valid;
   logic                          ready;
   logic [phsm_pkg::BYTE_W-1:0]   text_byte;
   logic                          last_byte;

   modport source (output valid, output text_byte, output last_byte, input ready);
   modport sink (input valid, input text_byte, input last_byte, output ready);
endinterface

interface phsm_rsp_if #(
   parameter int POSITION_BITS = 16
);
   logic                     valid;
   logic                     ready;
   logic                     match_found;
   logic                     window_ready;
   logic [POSITION_BITS-1:0] match_start;
   logic                     last_result;

   modport source (output valid, output match_found, output window_ready,
                   output match_start, output last_result, input ready);
   modport sink (input valid, input match_found, input window_ready,
                 input match_start, input last_result, output ready);
endinterface

// File: rtl/polynomial_hash_substring_match_top.sv
// Rabin-Karp substring matcher with base 31 and wrap-around 32-bit arithmetic. Each text
// byte beat on req_bus yields exactly one result beat on rsp_bus, in order; a new byte is
// taken every clock while results are being taken, and each accepted byte goes through the
// stage register and then the result register. That one-byte-per-cycle figure is set by the
// running prefix hash update (one 8 by 32 multiply-add per byte) and by the prefix history
// memory, which is written and read once per byte. Program pattern_hash and pattern_length
// through the csr port while no beat is in flight; a beat with last_byte set ends a text and
// clears the running state, and the history memory needs no clearing after reset.
module polynomial_hash_substring_match_top #(
   parameter int MAX_PATTERN = 64,
   parameter int POSITION_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [phsm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [phsm_pkg::CSR_DATA_W-1:0]      csr_wdata,
   phsm_req_if.sink                             req_bus,
   phsm_rsp_if.source                           rsp_bus
);
   import phsm_pkg::*;

   localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic [HASH_W-1:0]        pattern_hash_ff, pattern_hash_in;
   logic [LENGTH_W-1:0]      pattern_length_ff, pattern_length_in;

   logic                     stage_valid;
   logic                     stage_advance;
   phsm_stage_type           stage;
   logic [POSITION_BITS-1:0] stage_start;
   logic                     hist_write;
   logic [AW-1:0]            hist_write_addr;
   logic [HASH_W-1:0]        hist_write_data;
   logic                     hist_read;
   logic [AW-1:0]            hist_read_addr;
   logic [HASH_W-1:0]        hist_data;

   always_comb begin
      pattern_hash_in = pattern_hash_ff;
      pattern_length_in = pattern_length_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PATTERN_HASH: begin
               pattern_hash_in = HASH_W'(csr_wdata);
            end
            CSR_PATTERN_LENGTH: begin
               pattern_length_in = LENGTH_W'(csr_wdata);
            end
            default: begin
               pattern_hash_in = pattern_hash_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_hash_ff <= '0;
         pattern_length_ff <= LENGTH_W'(1);
      end else begin
         pattern_hash_ff <= pattern_hash_in;
         pattern_length_ff <= pattern_length_in;
      end
   end

   phsm_ram #(
      .WIDTH (HASH_W),
      .DEPTH (MAX_PATTERN),
      .AW    (AW)
   ) u_history (
      .clock        (clock),
      .write_enable (hist_write),
      .write_addr   (hist_write_addr),
      .write_data   (hist_write_data),
      .read_enable  (hist_read),
      .read_addr    (hist_read_addr),
      .read_data    (hist_data)
   );

   phsm_front #(
      .MAX_PATTERN   (MAX_PATTERN),
      .POSITION_BITS (POSITION_BITS),
      .AW            (AW)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_bus         (req_bus),
      .pattern_length  (pattern_length_ff),
      .stage_advance   (stage_advance),
      .stage_valid     (stage_valid),
      .stage           (stage),
      .stage_start     (stage_start),
      .hist_write      (hist_write),
      .hist_write_addr (hist_write_addr),
      .hist_write_data (hist_write_data),
      .hist_read       (hist_read),
      .hist_read_addr  (hist_read_addr)
   );

   phsm_match #(
      .POSITION_BITS (POSITION_BITS)
   ) u_match (
      .clock         (clock),
      .reset         (reset),
      .stage_valid   (stage_valid),
      .stage         (stage),
      .stage_start   (stage_start),
      .hist_data     (hist_data),
      .pattern_hash  (pattern_hash_ff),
      .stage_advance (stage_advance),
      .rsp_bus       (rsp_bus)
   );

endmodule

// File: rtl/phsm_ram.sv
module phsm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             write_enable,
   input  logic [AW-1:0]    write_addr,
   input  logic [WIDTH-1:0] write_data,
   input  logic             read_enable,
   input  logic [AW-1:0]    read_addr,
   output logic [WIDTH-1:0] read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

// File: rtl/phsm_front.sv
module phsm_front #(
   parameter int MAX_PATTERN = 64,
   parameter int POSITION_BITS = 16,
   parameter int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   phsm_req_if.sink                          req_bus,
   input  logic [phsm_pkg::LENGTH_W-1:0]     pattern_length,
   input  logic                              stage_advance,
   output logic                              stage_valid,
   output phsm_pkg::phsm_stage_type          stage,
   output logic [POSITION_BITS-1:0]          stage_start,
   output logic                              hist_write,
   output logic [AW-1:0]                     hist_write_addr,
   output logic [phsm_pkg::HASH_W-1:0]       hist_write_data,
   output logic                              hist_read,
   output logic [AW-1:0]                     hist_read_addr
);
   import phsm_pkg::*;

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int CMP_W = (LEN_W > LENGTH_W) ? LEN_W : LENGTH_W;
   localparam int CNT_W = ((POSITION_BITS > LEN_W) ? POSITION_BITS : LEN_W) + 1;
   localparam logic [CNT_W-1:0] POS_MAX = (CNT_W'(1) << POSITION_BITS) - CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_LIMIT = POS_MAX + CNT_W'(MAX_PATTERN);

   logic [HASH_W-1:0]  prefix_ff, prefix_in;
   logic [HASH_W-1:0]  power_end_ff, power_end_in;
   logic [HASH_W-1:0]  power_start_ff, power_start_in;
   logic [AW-1:0]      pointer_ff, pointer_in;
   logic [CNT_W-1:0]   position_ff, position_in;
   logic               stage_valid_ff, stage_valid_in;
   phsm_stage_type     stage_ff, stage_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;

   logic               accept;
   logic [CMP_W-1:0]   length_ext;
   logic [LEN_W-1:0]   window_len;
   logic [LEN_W-1:0]   len_minus_one;
   logic [CNT_W-1:0]   back_count;
   logic [CNT_W-1:0]   start_full;
   logic [AW:0]        pointer_ext;
   logic [AW:0]        back_ext;
   logic [AW:0]        back_sum;
   logic               ready_now;

   assign req_bus.ready = !stage_valid_ff || stage_advance;
   assign accept = req_bus.valid && req_bus.ready;

   always_comb begin
      length_ext = CMP_W'(pattern_length);
      if (length_ext == '0) begin
         window_len = LEN_W'(1);
      end else if (length_ext > CMP_W'(MAX_PATTERN)) begin
         window_len = LEN_W'(MAX_PATTERN);
      end else begin
         window_len = LEN_W'(length_ext);
      end
      len_minus_one = window_len - LEN_W'(1);
      back_count = CNT_W'(len_minus_one);
      ready_now = position_ff >= back_count;
      start_full = position_ff - back_count;
      pointer_ext = (AW + 1)'(pointer_ff);
      back_ext = (AW + 1)'(len_minus_one);
      if (pointer_ext >= back_ext) begin
         back_sum = pointer_ext - back_ext;
      end else begin
         back_sum = pointer_ext + (AW + 1)'(MAX_PATTERN) - back_ext;
      end
   end

   always_comb begin
      prefix_in = prefix_ff;
      power_end_in = power_end_ff;
      power_start_in = power_start_ff;
      pointer_in = pointer_ff;
      position_in = position_ff;
      stage_in = stage_ff;
      start_in = start_ff;
      stage_valid_in = stage_valid_ff;
      if (stage_advance) begin
         stage_valid_in = 1'b0;
      end
      if (accept) begin
         stage_valid_in = 1'b1;
         stage_in.hash_prev = prefix_ff;
         stage_in.hash_now = prefix_ff + HASH_W'(power_end_ff * HASH_W'(req_bus.text_byte));
         stage_in.power_start = power_start_ff;
         stage_in.window_ready = ready_now;
         stage_in.window_first = position_ff == back_count;
         stage_in.length_one = len_minus_one == '0;
         stage_in.last = req_bus.last_byte;
         if (!ready_now) begin
            start_in = '0;
         end else if (start_full > POS_MAX) begin
            start_in = POSITION_BITS'(POS_MAX);
         end else begin
            start_in = POSITION_BITS'(start_full);
         end
         if (req_bus.last_byte) begin
            prefix_in = '0;
            power_end_in = HASH_W'(1);
            power_start_in = HASH_W'(1);
            pointer_in = '0;
            position_in = '0;
         end else begin
            prefix_in = stage_in.hash_now;
            power_end_in = times_base(power_end_ff);
            if (ready_now) begin
               power_start_in = times_base(power_start_ff);
            end
            pointer_in = (pointer_ff == AW'(MAX_PATTERN - 1)) ? '0 : pointer_ff + AW'(1);
            if (position_ff < CNT_LIMIT) begin
               position_in = position_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= '0;
         power_end_ff <= HASH_W'(1);
         power_start_ff <= HASH_W'(1);
         pointer_ff <= '0;
         position_ff <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         prefix_ff <= prefix_in;
         power_end_ff <= power_end_in;
         power_start_ff <= power_start_in;
         pointer_ff <= pointer_in;
         position_ff <= position_in;
         stage_valid_ff <= stage_valid_in;
      end
      stage_ff <= stage_in;
      start_ff <= start_in;
   end

   assign stage_valid = stage_valid_ff;
   assign stage = stage_ff;
   assign stage_start = start_ff;
   assign hist_write = accept;
   assign hist_write_addr = pointer_ff;
   assign hist_write_data = prefix_ff;
   assign hist_read = accept;
   assign hist_read_addr = AW'(back_sum);

   // Powers of an odd base stay odd under wrap-around.
   assert property (@(posedge clock) disable iff (reset)
      power_end_ff[0] && power_start_ff[0])
      else $error("running power lost its odd bit");

   assert property (@(posedge clock) disable iff (reset)
      accept && req_bus.last_byte |=> pointer_ff == '0 && position_ff == '0 && prefix_ff == '0)
      else $error("running state not cleared after the last beat of a text");

   assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !stage_advance |=> stage_valid_ff && $stable(stage_ff))
      else $error("stalled stage lost its item");

endmodule

// File: rtl/phsm_match.sv
module phsm_match #(
   parameter int POSITION_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          stage_valid,
   input  phsm_pkg::phsm_stage_type      stage,
   input  logic [POSITION_BITS-1:0]      stage_start,
   input  logic [phsm_pkg::HASH_W-1:0]   hist_data,
   input  logic [phsm_pkg::HASH_W-1:0]   pattern_hash,
   output logic                          stage_advance,
   phsm_rsp_if.source                    rsp_bus
);
   import phsm_pkg::*;

   logic                     out_valid_ff, out_valid_in;
   logic                     found_ff, found_in;
   logic                     ready_ff, ready_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic                     last_ff, last_in;

   logic                     out_free;
   logic [HASH_W-1:0]        hash_before;
   logic [HASH_W-1:0]        window_hash;
   logic [HASH_W-1:0]        target_hash;

   assign out_free = !out_valid_ff || rsp_bus.ready;
   assign stage_advance = stage_valid && out_free;

   always_comb begin
      if (stage.window_first) begin
         hash_before = '0;
      end else if (stage.length_one) begin
         hash_before = stage.hash_prev;
      end else begin
         hash_before = hist_data;
      end
      window_hash = stage.hash_now - hash_before;
      target_hash = HASH_W'(pattern_hash * stage.power_start);
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      found_in = found_ff;
      ready_in = ready_ff;
      start_in = start_ff;
      last_in = last_ff;
      if (out_free) begin
         out_valid_in = stage_valid;
         found_in = stage.window_ready && (window_hash == target_hash);
         ready_in = stage.window_ready;
         start_in = stage_start;
         last_in = stage.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      found_ff <= found_in;
      ready_ff <= ready_in;
      start_ff <= start_in;
      last_ff <= last_in;
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.match_found = found_ff;
   assign rsp_bus.window_ready = ready_ff;
   assign rsp_bus.match_start = start_ff;
   assign rsp_bus.last_result = last_ff;

   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && found_ff |-> ready_ff)
      else $error("match reported before a full window");

   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !ready_ff |-> start_ff == '0)
      else $error("start position set before a full window");

   assert property (@(posedge clock) disable iff (reset)
      stage_advance |=> out_valid_ff)
      else $error("advanced item did not reach the result register");

endmodule

// File: tb/phsm_match_checker.sv
module phsm_match_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [phsm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [phsm_pkg::CSR_DATA_W-1:0]      csr_wdata,
   phsm_req_if                                  req_bus,
   phsm_rsp_if                                  rsp_bus,
   output int                                   fail_count,
   output int                                   pending_results,
   output int                                   result_count,
   output int                                   match_count
);
   import phsm_pkg::*;

   localparam int MAX_PATTERN = 64;
   localparam int POS_W = 16;
   localparam int POS_MAX = (1 << POS_W) - 1;
   localparam int PRINT_LIMIT = 100;

   typedef struct packed {
      logic             found;
      logic             ready;
      logic [POS_W-1:0] start;
      logic             last;
   } window_result_type;

   logic [HASH_W-1:0]   pattern_hash_q;
   logic [LENGTH_W-1:0] pattern_length_q;
   logic [HASH_W-1:0]   prefix_hash;
   logic [HASH_W-1:0]   power_end;
   logic [HASH_W-1:0]   power_start;
   logic [HASH_W-1:0]   prefix_seen [MAX_PATTERN];
   logic [5:0]          history_ptr;
   logic [POS_W:0]      text_pos;
   window_result_type   expected_windows [$];

   initial begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         prefix_seen[k] = '0;
      end
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (fail_count < PRINT_LIMIT) begin
         $display("ERROR at %0t: %s: got %0h, expected %0h", $time, what, got, want);
      end
      fail_count++;
   endtask

   task automatic clear_text();
      prefix_hash = '0;
      power_end = 32'd1;
      power_start = 32'd1;
      history_ptr = '0;
      text_pos = '0;
   endtask

   task automatic predict_window(input logic [BYTE_W-1:0] text_byte, input logic last);
      int                win_len;
      int                j;
      int                first;
      logic [5:0]        back;
      logic [31:0]       before_hash;
      logic [31:0]       window_hash;
      window_result_type r;
      if (pattern_length_q == 0) begin
         win_len = 1;
      end else if (pattern_length_q > MAX_PATTERN) begin
         win_len = MAX_PATTERN;
      end else begin
         win_len = int'(pattern_length_q);
      end
      j = int'(text_pos);
      r = '0;
      r.last = last;
      prefix_seen[history_ptr] = prefix_hash;
      prefix_hash = prefix_hash + {24'd0, text_byte} * power_end;
      power_end = power_end * HASH_BASE;
      if (j + 1 >= win_len) begin
         back = history_ptr - 6'(win_len - 1);
         before_hash = (j + 1 == win_len) ? 32'd0 : prefix_seen[back];
         window_hash = prefix_hash - before_hash;
         r.ready = 1'b1;
         r.found = (window_hash == pattern_hash_q * power_start);
         first = j + 1 - win_len;
         r.start = POS_W'((first > POS_MAX) ? POS_MAX : first);
         power_start = power_start * HASH_BASE;
      end
      history_ptr = history_ptr + 6'd1;
      if (text_pos < POS_MAX + MAX_PATTERN) begin
         text_pos = text_pos + 1'b1;
      end
      expected_windows.push_back(r);
      if (last) begin
         clear_text();
      end
   endtask

   task automatic check_result();
      window_result_type got;
      window_result_type want;
      got = {rsp_bus.match_found, rsp_bus.window_ready, rsp_bus.match_start,
             rsp_bus.last_result};
      result_count++;
      if (expected_windows.size() == 0) begin
         report_mismatch("result beat with no byte outstanding", got, 0);
      end else begin
         want = expected_windows.pop_front();
         if (want.found) begin
            match_count++;
         end
         if (got.found !== want.found) begin
            report_mismatch("match_found", got.found, want.found);
         end
         if (got.ready !== want.ready) begin
            report_mismatch("window_ready", got.ready, want.ready);
         end
         if (got.start !== want.start) begin
            report_mismatch("match_start", got.start, want.start);
         end
         if (got.last !== want.last) begin
            report_mismatch("last_result", got.last, want.last);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pattern_hash_q = '0;
         pattern_length_q = 7'd1;
         clear_text();
         expected_windows.delete();
         pending_results = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PATTERN_HASH: begin
                  pattern_hash_q = csr_wdata[HASH_W-1:0];
               end
               CSR_PATTERN_LENGTH: begin
                  pattern_length_q = csr_wdata[LENGTH_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            check_result();
         end
         if (req_bus.valid && req_bus.ready) begin
            predict_window(req_bus.text_byte, req_bus.last_byte);
         end
         pending_results = expected_windows.size();
      end
   end

endmodule

// File: tb/tb_polynomial_hash_substring_match_top.sv
module tb_polynomial_hash_substring_match_top;
   import phsm_pkg::*;

   localparam int MAX_PATTERN = 64;
   localparam int POSITION_BITS = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_BYTES = 480;
   localparam int LONG_TEXT_BYTES = 160;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   rsp_take = 1'b0;

   bit idle_on = 1'b0;
   int req_gap_odds = 4;
   int rsp_stall_odds = 4;
   int stall_left = 0;
   int quiet_cycles = 0;

   int fail_count;
   int pending_results;
   int result_count;
   int match_count;
   int bytes_sent = 0;
   int texts_sent = 0;
   int settings_used = 0;

   logic [BYTE_W-1:0] pattern_bytes [MAX_PATTERN];
   int                pattern_len = 1;

   phsm_req_if req_bus ();
   phsm_rsp_if #(.POSITION_BITS(POSITION_BITS)) rsp_bus ();

   assign rsp_bus.ready = rsp_take;

   polynomial_hash_substring_match_top #(
      .MAX_PATTERN(MAX_PATTERN),
      .POSITION_BITS(POSITION_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   phsm_match_checker i_checker (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .fail_count(fail_count),
      .pending_results(pending_results),
      .result_count(result_count),
      .match_count(match_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_take <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, rsp_stall_odds) == 0) begin
         rsp_take <= 1'b0;
         stall_left <= $urandom_range(0, 8);
      end else begin
         rsp_take <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no beat moved for %0d cycles, %0d results outstanding.",
                  quiet_cycles, pending_results);
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [31:0] hash_of_pattern();
      logic [31:0] acc;
      logic [31:0] pw;
      acc = '0;
      pw = 32'd1;
      for (int k = 0; k < pattern_len; k++) begin
         acc = acc + {24'd0, pattern_bytes[k]} * pw;
         pw = pw * 32'd31;
      end
      return acc;
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] value, input logic last);
      if (idle_on && $urandom_range(0, req_gap_odds) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.text_byte <= value;
      req_bus.last_byte <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      bytes_sent++;
      if (last) begin
         texts_sent++;
      end
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   task automatic set_pattern(input logic [31:0] hash, input logic [LENGTH_W-1:0] length);
      csr_we <= 1'b1;
      csr_index <= CSR_PATTERN_HASH;
      csr_wdata <= hash;
      @(posedge clock);
      csr_index <= CSR_PATTERN_LENGTH;
      csr_wdata <= CSR_DATA_W'(length);
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic new_pattern(input int length_reg);
      bit narrow;
      narrow = $urandom_range(0, 1);
      if (length_reg == 0) begin
         pattern_len = 1;
      end else if (length_reg > MAX_PATTERN) begin
         pattern_len = MAX_PATTERN;
      end else begin
         pattern_len = length_reg;
      end
      for (int k = 0; k < pattern_len; k++) begin
         pattern_bytes[k] = narrow ? 8'($urandom_range(8'h61, 8'h63)) : 8'($urandom);
      end
      set_pattern(($urandom_range(0, 7) == 0) ? 32'($urandom) : hash_of_pattern(),
                  LENGTH_W'(length_reg));
   endtask

   task automatic send_text(input int segments, input bit finish);
      int                flip;
      int                n;
      bit                near_miss;
      logic [BYTE_W-1:0] b;
      for (int s = 0; s < segments; s++) begin
         if ($urandom_range(0, 1) == 1) begin
            flip = ($urandom_range(0, 3) == 0) ? $urandom_range(0, pattern_len - 1) : -1;
            for (int k = 0; k < pattern_len; k++) begin
               b = pattern_bytes[k];
               if (k == flip) begin
                  b = b ^ 8'(1 << $urandom_range(0, 7));
               end
               send_byte(b, finish && s == segments - 1 && k == pattern_len - 1);
            end
         end else begin
            n = $urandom_range(1, 6);
            near_miss = $urandom_range(0, 1);
            for (int k = 0; k < n; k++) begin
               b = near_miss ? pattern_bytes[$urandom_range(0, pattern_len - 1)] : 8'($urandom);
               send_byte(b, finish && s == segments - 1 && k == n - 1);
            end
         end
      end
   endtask

   task automatic pick_idle_mode();
      idle_on = ($urandom_range(0, 3) != 0);
      req_gap_odds = $urandom_range(1, 6);
      rsp_stall_odds = $urandom_range(1, 6);
   endtask

   initial begin
      int length_reg;
      int texts;
      int phase;
      logic [BYTE_W-1:0] b;
      req_bus.valid = 1'b0;
      req_bus.text_byte = '0;
      req_bus.last_byte = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_PATTERN_HASH;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed texts run on the reset settings first: zero hash, length one.
      idle_on = 1'b1;
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      drain_results();

      pattern_bytes[0] = 8'h41;
      pattern_bytes[1] = 8'h42;
      pattern_len = 2;
      set_pattern(hash_of_pattern(), 7'd2);
      send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b1);
      drain_results();

      // A zero length acts as one, and a length above the history depth is clamped.
      set_pattern(32'd255 * 32'd31, 7'd0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h7F, 1'b1);
      drain_results();

      set_pattern(32'hFFFF_FFFF, 7'd127);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'hAA, 1'b1);
      drain_results();

      // The length changes in the middle of a text, with the window already open.
      pattern_bytes[0] = 8'h01;
      pattern_bytes[1] = 8'h02;
      pattern_bytes[2] = 8'h03;
      pattern_len = 3;
      set_pattern(hash_of_pattern(), 7'd3);
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'h03, 1'b0);
      send_byte(8'h01, 1'b0);
      drain_results();
      pattern_bytes[0] = 8'h02;
      pattern_bytes[1] = 8'h03;
      pattern_len = 2;
      set_pattern(hash_of_pattern(), 7'd2);
      send_byte(8'h02, 1'b0);
      send_byte(8'h03, 1'b0);
      send_byte(8'h00, 1'b1);
      drain_results();

      phase = 0;
      while (bytes_sent < RANDOM_BYTES) begin
         if (phase == 0) begin
            length_reg = MAX_PATTERN;
         end else if (phase == 1) begin
            length_reg = 127;
         end else begin
            case ($urandom_range(0, 15))
               0: length_reg = 0;
               1: length_reg = MAX_PATTERN;
               2: length_reg = $urandom_range(MAX_PATTERN + 1, 127);
               3, 4: length_reg = $urandom_range(9, MAX_PATTERN - 1);
               default: length_reg = $urandom_range(1, 8);
            endcase
         end
         phase++;
         new_pattern(length_reg);
         pick_idle_mode();
         texts = $urandom_range(1, 3);
         for (int t = 0; t < texts; t++) begin
            send_text($urandom_range(1, (pattern_len > 8) ? 4 : 10),
                      t < texts - 1 || $urandom_range(0, 4) != 0);
         end
         drain_results();
      end

      // One text without any idling sends its bytes back to back.
      idle_on = 1'b0;
      pattern_bytes[0] = 8'h41;
      pattern_bytes[1] = 8'h42;
      pattern_len = 2;
      set_pattern(hash_of_pattern(), 7'd2);
      for (int i = 0; i < LONG_TEXT_BYTES; i++) begin
         if ($urandom_range(0, 15) == 0) begin
            b = 8'($urandom);
         end else begin
            b = ($urandom_range(0, 1) == 1) ? 8'h41 : 8'h42;
         end
         send_byte(b, i == LONG_TEXT_BYTES - 1);
      end
      drain_results();
      repeat (8) @(posedge clock);

      $display("Sent %0d text bytes in %0d texts under %0d register settings.",
               bytes_sent, texts_sent, settings_used);
      $display("Checked %0d result beats, %0d of them matches, with one text of %0d bytes.",
               result_count, match_count, LONG_TEXT_BYTES);
      if (fail_count == 0 && pending_results == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
